// ===== hw/rtl/dpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared types, codes and the CRC-16/XMODEM byte update for the deframer.
// ----------------------------------------------------------------------------
package dpd_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;
	localparam int HDR_BYTES       = 6;
	localparam int CRC_BYTES       = 2;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0]  DELIM_RST   = 8'd126;
	localparam logic [5:0]  MAX_LEN_RST = 6'd33;
	localparam logic [15:0] TIMEOUT_RST = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELIMITER = 2'd0,
		CFG_MAX_LEN   = 2'd1,
		CFG_TIMEOUT   = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_GOOD         = 2'd0,
		ST_CRC          = 2'd1,
		ST_INVALID      = 2'd2,
		ST_HUNT_TIMEOUT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_HEAD = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef struct packed {
		logic       is_tick;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic       is_status;
		logic [7:0] data;
		logic [4:0] position;
		logic [1:0] status;
	} out_t;

	typedef struct packed {
		logic [7:0]  delimiter;
		logic [5:0]  max_len;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// MSB-first CRC update, one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15])
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/dpd_core.sv =====
// ----------------------------------------------------------------------------
// dpd_core
// Input register, framing state update and result register of the deframer.
// ----------------------------------------------------------------------------
module dpd_core import dpd_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_item,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_item
);

	localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);
	localparam logic [6:0] LIM_MAX = 7'(MAX_PAYLOAD + 1);

	// input stage
	logic v_s1;
	in_t  item_s1;

	// framing state
	phase_t            phase_q, phase_n;
	logic [2:0]        hdr_cnt_q, hdr_cnt_n;
	logic [15:0]       rx_crc_q, rx_crc_n;
	logic [31:0]       bitmap_q, bitmap_n;
	logic [IDX_W-1:0]  pidx_q, pidx_n;
	logic [15:0]       run_crc_q, run_crc_n;
	logic [15:0]       elapsed_q, elapsed_n;
	logic              timer_q, timer_n;

	// result
	logic out_valid_q;
	out_t out_q;

	logic        has_res;
	out_t        res;
	logic        go_hunt;
	logic        adv;
	logic [6:0]  limit;
	logic [6:0]  pidx_inc;
	logic [4:0]  pos;
	logic [7:0]  dec;

	assign limit    = ({1'b0, cfg.max_len} > LIM_MAX) ? LIM_MAX : {1'b0, cfg.max_len};
	assign pidx_inc = 7'(pidx_q) + 7'd1;
	assign pos      = 5'(pidx_q);
	assign dec      = bitmap_q[pos] ? cfg.delimiter : item_s1.rx_byte;

	always_comb begin
		phase_n   = phase_q;
		hdr_cnt_n = hdr_cnt_q;
		rx_crc_n  = rx_crc_q;
		bitmap_n  = bitmap_q;
		pidx_n    = pidx_q;
		run_crc_n = run_crc_q;
		elapsed_n = elapsed_q;
		timer_n   = timer_q;
		has_res   = 1'b0;
		res       = '0;
		go_hunt   = 1'b0;

		if (item_s1.is_tick) begin
			if (timer_q) begin
				if (elapsed_q >= cfg.timeout_ticks) begin
					has_res       = 1'b1;
					res.is_status = 1'b1;
					res.status    = (phase_q == PH_HEAD || phase_q == PH_BODY) ?
						ST_INVALID : ST_HUNT_TIMEOUT;
					go_hunt       = 1'b1;
				end else begin
					elapsed_n = elapsed_q + 16'd1;
				end
			end
		end else begin
			if (!timer_q) begin
				timer_n   = 1'b1;
				elapsed_n = '0;
			end
			unique case (phase_q)
				PH_HEAD: begin
					if (hdr_cnt_q < 3'(CRC_BYTES))
						rx_crc_n = {rx_crc_q[7:0], item_s1.rx_byte};
					else
						bitmap_n = {bitmap_q[23:0], item_s1.rx_byte};
					hdr_cnt_n = hdr_cnt_q + 3'd1;
					if (hdr_cnt_n >= 3'(HDR_BYTES)) begin
						phase_n   = PH_BODY;
						pidx_n    = '0;
						run_crc_n = '0;
					end
				end
				PH_BODY: begin
					if (item_s1.rx_byte == cfg.delimiter) begin
						has_res       = 1'b1;
						res.is_status = 1'b1;
						res.status    = (run_crc_q == rx_crc_q) ? ST_GOOD : ST_CRC;
						go_hunt       = 1'b1;
					end else if (pidx_inc >= limit) begin
						has_res       = 1'b1;
						res.is_status = 1'b1;
						res.status    = ST_INVALID;
						go_hunt       = 1'b1;
					end else begin
						run_crc_n    = crc_byte(run_crc_q, dec);
						pidx_n       = pidx_q + IDX_W'(1);
						has_res      = 1'b1;
						res.data     = dec;
						res.position = pos;
					end
				end
				default: begin
					// hunting; the unused code behaves the same
					if (item_s1.rx_byte == cfg.delimiter) begin
						phase_n   = PH_HEAD;
						hdr_cnt_n = '0;
						rx_crc_n  = '0;
						bitmap_n  = '0;
					end
				end
			endcase
		end

		if (go_hunt) begin
			phase_n   = PH_HUNT;
			hdr_cnt_n = '0;
			pidx_n    = '0;
			timer_n   = 1'b0;
			elapsed_n = '0;
		end
	end

	// the stage moves on unless its result would land on a held result
	assign adv      = v_s1 && (!has_res || !out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			hdr_cnt_q <= '0;
			rx_crc_q  <= '0;
			bitmap_q  <= '0;
			pidx_q    <= '0;
			run_crc_q <= '0;
			elapsed_q <= '0;
			timer_q   <= 1'b0;
		end else if (adv) begin
			phase_q   <= phase_n;
			hdr_cnt_q <= hdr_cnt_n;
			rx_crc_q  <= rx_crc_n;
			bitmap_q  <= bitmap_n;
			pidx_q    <= pidx_n;
			run_crc_q <= run_crc_n;
			elapsed_q <= elapsed_n;
			timer_q   <= timer_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && has_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_timer_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HUNT) |-> timer_q)
		else $error("frame in progress with timer stopped");

	a_idle_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!timer_q |-> (elapsed_q == 16'd0))
		else $error("stopped timer holds a count");

	// the count rests at the header length for the whole payload
	a_hdr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= 3'(HDR_BYTES))
		else $error("header count past header length");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		7'(pidx_q) <= 7'(MAX_PAYLOAD))
		else $error("payload index past maximum");

	a_status_rehunt: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && has_res && res.is_status) |=> (phase_q == PH_HUNT && !timer_q))
		else $error("status did not return to hunting");

endmodule

// ===== hw/rtl/delimited_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// delimited_packet_deframer
// Delimiter-framed packet receiver with escape bitmap and CRC-16/XMODEM check.
// ----------------------------------------------------------------------------
// Takes one transaction per clock, byte or tick, while no result is blocked. Each
// accepted transaction is registered, then its framing update and any result are
// computed combinationally and written to the output register when the stage
// advances, which a held result can delay. in_ready stays high while
// the output register is free or being drained; it drops only when a
// transaction that makes a result finds the previous result still waiting.
// Configuration writes are taken every cycle (cfg_ready is always high) and
// must only occur while the block is idle.
module delimited_packet_deframer import dpd_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_item
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter     <= DELIM_RST;
			cfg_q.max_len       <= MAX_LEN_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DELIMITER: cfg_q.delimiter     <= cfg_data[7:0];
				CFG_MAX_LEN:   cfg_q.max_len       <= cfg_data[5:0];
				CFG_TIMEOUT:   cfg_q.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	dpd_core #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== dv/delimited_packet_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_packet_deframer_tb
// Self-checking bench for the deframer. Byte and tick transactions go in, and
// an in-bench predictor tracks framing, escape decoding, the CRC-16/XMODEM
// check, the length limit and the tick timeout. Every output transaction is
// compared field by field. Directed frames and config corners come first, then
// random streams under several configurations, most with random stalls on both sides.
// ----------------------------------------------------------------------------
module delimited_packet_deframer_tb;
	import dpd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 4;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	in_t                   in_item;
	logic                  out_valid;
	logic                  out_ready;
	out_t                  out_item;

	delimited_packet_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	// predictor config and framing state
	logic [7:0]  cfg_delim   = DELIM_RST;
	logic [5:0]  cfg_maxlen  = MAX_LEN_RST;
	logic [15:0] cfg_timeout = TIMEOUT_RST;
	phase_t      rx_phase    = PH_HUNT;
	int          hdr_cnt     = 0;
	logic [15:0] hdr_crc     = '0;
	logic [31:0] esc_map     = '0;
	logic [5:0]  pay_idx     = '0;
	logic [15:0] run_crc     = '0;
	logic [15:0] tick_cnt    = '0;
	bit          timer_on    = 1'b0;

	out_t       deframed_q[$];
	logic [7:0] frame_bytes[$];
	int         error_count   = 0;
	int         items_counted = 0;
	int         cycle_count   = 0;
	int         tick_odds     = 0;
	int         rx_hold       = 0;
	bit         idle_en       = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [15:0] crc16_xmodem(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c;
		for (int i = 7; i >= 0; i--) begin
			if (r[15] ^ b[i])
				r = {r[14:0], 1'b0} ^ CRC_POLY;
			else
				r = {r[14:0], 1'b0};
		end
		return r;
	endfunction

	task automatic close_packet(status_t st);
		out_t r;
		r.is_status = 1'b1;
		r.data      = '0;
		r.position  = '0;
		r.status    = st;
		deframed_q.push_back(r);
		rx_phase = PH_HUNT;
		hdr_cnt  = 0;
		pay_idx  = '0;
		timer_on = 1'b0;
		tick_cnt = '0;
	endtask

	task automatic deframe_predict(in_t it);
		out_t       r;
		int         lim;
		logic [7:0] dec;
		if (it.is_tick) begin
			if (!timer_on)
				return;
			if (tick_cnt >= cfg_timeout) begin
				close_packet(rx_phase == PH_HUNT ? ST_HUNT_TIMEOUT : ST_INVALID);
				return;
			end
			tick_cnt++;
			return;
		end
		if (!timer_on) begin
			timer_on = 1'b1;
			tick_cnt = '0;
		end
		case (rx_phase)
			PH_HEAD: begin
				if (hdr_cnt < CRC_BYTES)
					hdr_crc = {hdr_crc[7:0], it.rx_byte};
				else
					esc_map = {esc_map[23:0], it.rx_byte};
				hdr_cnt++;
				if (hdr_cnt >= HDR_BYTES) begin
					rx_phase = PH_BODY;
					pay_idx  = '0;
					run_crc  = '0;
				end
			end
			PH_BODY: begin
				if (it.rx_byte == cfg_delim) begin
					close_packet(run_crc == hdr_crc ? ST_GOOD : ST_CRC);
					return;
				end
				lim = (cfg_maxlen > MAX_PAYLOAD_DEF + 1) ? MAX_PAYLOAD_DEF + 1 : int'(cfg_maxlen);
				if (int'(pay_idx) + 1 >= lim) begin
					close_packet(ST_INVALID);
					return;
				end
				dec = esc_map[pay_idx[4:0]] ? cfg_delim : it.rx_byte;
				run_crc = crc16_xmodem(run_crc, dec);
				r.is_status = 1'b0;
				r.data      = dec;
				r.position  = pay_idx[4:0];
				r.status    = ST_GOOD;
				deframed_q.push_back(r);
				pay_idx++;
			end
			default: begin
				if (it.rx_byte == cfg_delim) begin
					rx_phase = PH_HEAD;
					hdr_cnt  = 0;
					hdr_crc  = '0;
					esc_map  = '0;
				end
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		error_count++;
		$display("%0t ns: %s mismatch, got %0h, expected %0h", $realtime, what, got, want);
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(in_t it);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		items_counted++;
		deframe_predict(it);
		@(negedge clk);
	endtask

	task automatic send_tick();
		in_t it;
		it.is_tick = 1'b1;
		it.rx_byte = 8'($urandom_range(0, 255));
		send_item(it);
	endtask

	task automatic send_byte(logic [7:0] b);
		in_t it;
		if (tick_odds > 0 && $urandom_range(1, 100) <= tick_odds)
			send_tick();
		it.is_tick = 1'b0;
		it.rx_byte = b;
		send_item(it);
	endtask

	// raw payload taken from frame_bytes; header CRC covers the decoded bytes
	task automatic send_frame(logic [31:0] esc, bit bad_crc, bit closed);
		logic [15:0] crc;
		crc = '0;
		foreach (frame_bytes[i])
			crc = crc16_xmodem(crc, esc[i % 32] ? cfg_delim : frame_bytes[i]);
		if (bad_crc)
			crc ^= 16'($urandom_range(1, 65535));
		send_byte(cfg_delim);
		send_byte(crc[15:8]);
		send_byte(crc[7:0]);
		for (int k = 3; k >= 0; k--)
			send_byte(esc[8*k +: 8]);
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i]);
		if (closed)
			send_byte(cfg_delim);
	endtask

	task automatic fill_payload(int len);
		logic [7:0] b;
		frame_bytes.delete();
		repeat (len) begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == cfg_delim);
			frame_bytes.push_back(b);
		end
	endtask

	// sender pause: let every expected result drain, then let the pipe settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (deframed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		case (idx)
			CFG_DELIMITER: cfg_delim   = v[7:0];
			CFG_MAX_LEN:   cfg_maxlen  = v[5:0];
			CFG_TIMEOUT:   cfg_timeout = v;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_basic_frames();
		tick_odds = 0;
		send_tick();  // timer stopped, ignored
		send_tick();
		send_byte(8'h00);  // hunting noise starts the timer
		send_byte(8'hFF);
		// escaped positions 0 and 2, bitmap holds the delimiter value
		frame_bytes.delete();
		frame_bytes.push_back(8'hFF);
		frame_bytes.push_back(8'h00);
		frame_bytes.push_back(8'h12);
		send_frame(32'h7E00_0005, 1'b0, 1'b1);
		frame_bytes.delete();
		frame_bytes.push_back(8'h34);
		send_tick();
		send_frame(32'hFFFF_FFFF, 1'b1, 1'b1);
		frame_bytes.delete();
		send_frame(32'h0000_0000, 1'b0, 1'b1);
	endtask

	task automatic test_backpressure();
		rx_hold = 300;
		fill_payload(32);
		send_frame($urandom, 1'b0, 1'b1);
		fill_payload(33);  // last byte hits the default length limit
		send_frame($urandom, 1'b0, 1'b0);
		wait_drained();
	endtask

	task automatic test_config_corners();
		cfg_write(CFG_UNUSED, 16'hFFFF);
		cfg_write(CFG_DELIMITER, 16'hA5C3);  // upper bits dropped
		cfg_write(CFG_MAX_LEN, 16'hFFC0);    // zero: first payload byte is invalid
		fill_payload(1);
		send_frame(32'h0, 1'b0, 1'b0);
		cfg_write(CFG_TIMEOUT, 16'd0);
		send_byte(8'h3C);
		send_tick();  // fires while hunting
		send_tick();
		cfg_write(CFG_TIMEOUT, 16'd2);
		send_byte(8'hC3);
		send_byte(8'h01);
		send_byte(8'h02);
		repeat (3) send_tick();  // fires inside the header
	endtask

	task automatic run_phase(logic [7:0] d, logic [5:0] m, logic [15:0] t, int n, int odds);
		logic [15:0] junk;
		int          target;
		int          kind;
		junk = 16'($urandom);
		cfg_write(CFG_DELIMITER, {junk[7:0], d});
		cfg_write(CFG_MAX_LEN, {junk[15:6], m});
		cfg_write(CFG_TIMEOUT, t);
		tick_odds = odds;
		target = items_counted + n;
		while (items_counted < target) begin
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				fill_payload($urandom_range(0, 7) == 0 ? $urandom_range(0, 36)
					: $urandom_range(0, 8));
				send_frame($urandom_range(0, 3) == 0 ? 32'h0 : $urandom,
					$urandom_range(0, 3) == 0, 1'b1);
			end else if (kind == 14) begin
				fill_payload($urandom_range(0, 4));
				send_frame($urandom, 1'b0, 1'b0);
			end else if (kind == 15) begin
				send_byte(cfg_delim);
				repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
			end else if (kind < 18) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 40)) send_tick();
			end
		end
	endtask

	task automatic test_random_streams();
		idle_en = 1'b1;
		run_phase(8'($urandom_range(0, 255)), 6'($urandom_range(1, 40)),
			16'($urandom_range(4, 40)), 280, 4);
		run_phase(8'h00, 6'd63, 16'hFFFF, 280, 8);
		run_phase(8'hFF, 6'd1, 16'd0, 140, 2);
		run_phase(8'h7E, 6'd33, 16'd1000, 280, 8);
		idle_en = 1'b0;
		run_phase(8'($urandom_range(0, 255)), 6'd20, 16'd30, 340, 4);
	endtask

	// output side: random stalls, plus one long hold on request
	always begin
		@(negedge clk);
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			repeat (rx_hold) @(negedge clk);
			rx_hold = 0;
			out_ready <= 1'b1;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (deframed_q.size() == 0) begin
				report_mismatch("unexpected transaction", 16'(out_item), '0);
			end else begin
				want = deframed_q.pop_front();
				if (out_item.is_status !== want.is_status)
					report_mismatch("is_status", out_item.is_status, want.is_status);
				if (out_item.data !== want.data)
					report_mismatch("data", out_item.data, want.data);
				if (out_item.position !== want.position)
					report_mismatch("position", out_item.position, want.position);
				if (out_item.status !== want.status)
					report_mismatch("status", out_item.status, want.status);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("delimited_packet_deframer_tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_item   = '0;
		out_ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_basic_frames();
		test_backpressure();
		test_config_corners();
		test_random_streams();
		wait_drained();
		if (error_count == 0)
			$display("delimited_packet_deframer_tb: clean");
		else
			$display("delimited_packet_deframer_tb: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/dpd_pkg.sv
hw/rtl/dpd_core.sv
hw/rtl/delimited_packet_deframer.sv
dv/delimited_packet_deframer_tb.sv
